[design/efws_pkg.sv]
// Shared constants and types for the earliest-free worker scheduler.
// No dependencies; efws_heap and earliest_free_worker_scheduler refer to this package by scope.
package efws_pkg;

    localparam int WORKERS_DEF   = 256;
    localparam int TIME_BITS_DEF = 48;

    localparam int DUR_BITS   = 32;
    localparam int WC_BITS    = 9;
    localparam int INDEX_BITS = 8;

    // Register indexes on the configuration port
    localparam int REG_WORKER_COUNT = 0;
    localparam logic [WC_BITS-1:0] WC_RESET = 9'd1;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_SIFT
    } t_state;

endpackage

[design/efws_ram.sv]
// Generic synchronous RAM: one write port, two read ports, registered reads.
// No dependencies.
module efws_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr_a,
    input  logic [AW-1:0]    i_raddr_b,
    output logic [WIDTH-1:0] o_rdata_a,
    output logic [WIDTH-1:0] o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

[design/efws_heap.sv]
// Min-heap of {free time, worker index} keys held in efws_ram, with the root
// mirrored in a register. Replace-root and sift-down per job. Uses efws_pkg.
module efws_heap #(
    parameter int WORKERS   = efws_pkg::WORKERS_DEF,
    parameter int TIME_BITS = efws_pkg::TIME_BITS_DEF,
    parameter int AW        = (WORKERS > 1) ? $clog2(WORKERS) : 1,
    parameter int LW        = AW + 2
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_clear,
    input  logic [LW-1:0]                   i_count,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [efws_pkg::DUR_BITS-1:0]   i_duration,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [efws_pkg::INDEX_BITS-1:0] o_index,
    output logic [TIME_BITS-1:0]            o_start
);

    localparam int KW = TIME_BITS + AW;

    efws_pkg::t_state r_state, n_state;
    logic [LW-1:0] r_pos, n_pos;
    logic [AW:0]   r_cnt, n_cnt;
    logic [KW-1:0] r_key, n_key;
    logic [KW-1:0] r_top, n_top;
    logic          r_ovalid, n_ovalid;
    logic [efws_pkg::INDEX_BITS-1:0] r_oindex, n_oindex;
    logic [TIME_BITS-1:0] r_ostart, n_ostart;

    logic          w_we;
    logic [AW-1:0] w_waddr, w_raddr_a, w_raddr_b;
    logic [KW-1:0] w_wdata, w_data_l, w_data_r;
    logic [LW-1:0] w_lpos, w_rpos, w_cpos;
    logic [KW-1:0] w_ckey;
    logic          w_lv, w_rv, w_use_r, w_down, w_accept;
    logic [TIME_BITS:0] w_sum;
    logic [TIME_BITS-1:0] w_finish;

    efws_ram #(.WIDTH(KW), .DEPTH(WORKERS), .AW(AW)) u_ram (
        .i_clk     (i_clk),
        .i_we      (w_we),
        .i_waddr   (w_waddr),
        .i_wdata   (w_wdata),
        .i_raddr_a (w_raddr_a),
        .i_raddr_b (w_raddr_b),
        .o_rdata_a (w_data_l),
        .o_rdata_b (w_data_r)
    );

    assign o_ready  = (r_state == efws_pkg::S_IDLE) && (!r_ovalid || i_ready);
    assign w_accept = i_valid && o_ready;
    assign o_valid  = r_ovalid;
    assign o_index  = r_oindex;
    assign o_start  = r_ostart;

    // Children of the current position
    assign w_lpos  = LW'({r_pos, 1'b1});
    assign w_rpos  = w_lpos + LW'(1);
    assign w_lv    = w_lpos < i_count;
    assign w_rv    = w_rpos < i_count;
    assign w_use_r = w_rv && (w_data_r < w_data_l);
    assign w_ckey  = w_use_r ? w_data_r : w_data_l;
    assign w_cpos  = w_use_r ? w_rpos : w_lpos;
    assign w_down  = w_lv && (w_ckey < r_key);

    // Saturating finish time of the root worker
    assign w_sum    = {1'b0, r_top[KW-1:AW]} + (TIME_BITS+1)'(i_duration);
    assign w_finish = w_sum[TIME_BITS] ? '1 : w_sum[TIME_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= efws_pkg::S_CLEAR;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
            r_top    <= '0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_ovalid <= n_ovalid;
            r_top    <= n_top;
        end
        r_pos    <= n_pos;
        r_key    <= n_key;
        r_oindex <= n_oindex;
        r_ostart <= n_ostart;
    end

    always_comb begin
        n_state   = r_state;
        n_pos     = r_pos;
        n_cnt     = r_cnt;
        n_key     = r_key;
        n_top     = r_top;
        n_ovalid  = r_ovalid && !i_ready;
        n_oindex  = r_oindex;
        n_ostart  = r_ostart;
        w_we      = 1'b0;
        w_waddr   = r_pos[AW-1:0];
        w_wdata   = r_key;
        w_raddr_a = AW'(1);
        w_raddr_b = AW'(2);
        case (r_state)
            efws_pkg::S_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_cnt[AW-1:0];
                w_wdata = {{TIME_BITS{1'b0}}, r_cnt[AW-1:0]};
                n_top   = '0;
                n_cnt   = r_cnt + (AW+1)'(1);
                if (r_cnt == (AW+1)'(WORKERS - 1)) begin
                    n_state = efws_pkg::S_IDLE;
                end
            end
            efws_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_ovalid = 1'b1;
                    n_oindex = efws_pkg::INDEX_BITS'(r_top[AW-1:0]);
                    n_ostart = r_top[KW-1:AW];
                    n_key    = {w_finish, r_top[AW-1:0]};
                    n_pos    = '0;
                    n_state  = efws_pkg::S_SIFT;
                end
            end
            efws_pkg::S_SIFT: begin
                w_we = 1'b1;
                if (w_down) begin
                    // Pull the smaller child up and descend
                    w_wdata   = w_ckey;
                    n_pos     = w_cpos;
                    w_raddr_a = AW'({w_cpos, 1'b1});
                    w_raddr_b = AW'({w_cpos, 1'b1} + (LW+1)'(1));
                    if (r_pos == '0) begin
                        n_top = w_ckey;
                    end
                end else begin
                    w_wdata = r_key;
                    if (r_pos == '0) begin
                        n_top = r_key;
                    end
                    n_state = efws_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = efws_pkg::S_CLEAR;
                n_cnt   = '0;
            end
        endcase
        if (i_clear) begin
            n_state = efws_pkg::S_CLEAR;
            n_cnt   = '0;
            n_top   = '0;
        end
    end

    a_accept_sift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !i_clear) |=> (r_state == efws_pkg::S_SIFT))
        else $error("accepted job did not start a sift");

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == efws_pkg::S_SIFT) |-> (r_pos < i_count))
        else $error("sift position beyond heap size");

    a_clear_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == efws_pkg::S_CLEAR) |-> !o_ready)
        else $error("input taken during clearing pass");

endmodule

[design/earliest_free_worker_scheduler.sv]
// Channel    Handshake            Payload
// job in     i_valid / o_ready    i_job_duration[31:0]
// result     o_valid / i_ready    o_worker_index[7:0], o_start_time[TIME_BITS-1:0]
// config     APB psel/penable     paddr[1:0], pwdata/prdata[31:0] (worker_count @ 0x0)
//
// A job is accepted in idle, then the new key sinks down the heap, at most log2 of the
// worker count levels, one heap level per cycle through the dual-read heap RAM.
// After reset and after each worker_count write, a clearing pass over all WORKERS
// entries refills the heap; no job is taken meanwhile.
// A result waits in an output register; the next job is taken when it drains.
module earliest_free_worker_scheduler #(
    parameter int WORKERS   = efws_pkg::WORKERS_DEF,
    parameter int TIME_BITS = efws_pkg::TIME_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [1:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [31:0]           i_job_duration,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [7:0]            o_worker_index,
    output logic [TIME_BITS-1:0]  o_start_time
);

    localparam int AW = (WORKERS > 1) ? $clog2(WORKERS) : 1;
    localparam int LW = AW + 2;

    logic [efws_pkg::WC_BITS-1:0] r_wc, n_wc;
    logic          w_wr;
    logic [LW-1:0] w_count;

    // Only one register, worker_count at address 0; drop writes to any other address
    assign w_wr   = psel && penable && pwrite &&
                    (paddr[1:0] == 2'(4 * efws_pkg::REG_WORKER_COUNT));
    assign pready = 1'b1;
    assign prdata = 32'(r_wc);
    assign n_wc   = w_wr ? pwdata[efws_pkg::WC_BITS-1:0] : r_wc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wc <= efws_pkg::WC_RESET;
        end else begin
            r_wc <= n_wc;
        end
    end

    always_comb begin
        if (r_wc == '0) begin
            w_count = LW'(1);
        end else if (32'(r_wc) > 32'(WORKERS)) begin
            w_count = LW'(WORKERS);
        end else begin
            w_count = LW'(r_wc);
        end
    end

    efws_heap #(.WORKERS(WORKERS), .TIME_BITS(TIME_BITS), .AW(AW), .LW(LW)) u_heap (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_clear    (w_wr),
        .i_count    (w_count),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_duration (i_job_duration),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_index    (o_worker_index),
        .o_start    (o_start_time)
    );

endmodule

[bench/tb_top.sv]
// Self-checking testbench for the earliest-free worker scheduler.
// Depends on efws_pkg and earliest_free_worker_scheduler; drives jobs and APB writes.
`timescale 1ns / 1ps

module tb_top;

    localparam int NW = efws_pkg::WORKERS_DEF;
    localparam int TB = efws_pkg::TIME_BITS_DEF;
    localparam logic [TB-1:0] TIME_MAX = {TB{1'b1}};
    localparam int STALL_LIMIT = 20000;
    localparam int HOLD_LEN = 300;

    typedef struct packed {
        logic [efws_pkg::INDEX_BITS-1:0] worker;
        logic [TB-1:0]                   start;
    } t_assign;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic i_valid = 1'b0;
    logic o_ready;
    logic [31:0] i_job_duration = '0;
    logic o_valid;
    logic i_ready = 1'b0;
    logic [7:0] o_worker_index;
    logic [TB-1:0] o_start_time;

    earliest_free_worker_scheduler u_top (.*);

    always #2 i_clk = ~i_clk;

    // predictor state
    logic [TB-1:0] free_at [NW];
    logic [efws_pkg::WC_BITS-1:0] workers_cfg;

    logic [31:0] job_queue[$];
    t_assign assign_queue[$];
    int  fail_count = 0;
    int  idle_cycles = 0;
    bit  hold_sink = 1'b0;
    int  hold_cnt = 0;
    int  sink_gap = 0;
    int  src_gap = 0;

    function automatic int gap_len();
        if ($urandom_range(0, 19) == 0) return $urandom_range(20, 80);
        if ($urandom_range(0, 2) == 0) return 0;
        return $urandom_range(0, 3);
    endfunction

    function automatic t_assign schedule_job(input logic [31:0] dur);
        int n, best;
        t_assign r;
        logic [TB:0] fin;
        n = (workers_cfg == 0) ? 1 : ((workers_cfg > NW) ? NW : int'(workers_cfg));
        best = 0;
        for (int i = 1; i < n; i++)
            if (free_at[i] < free_at[best]) best = i;
        r.worker = best[efws_pkg::INDEX_BITS-1:0];
        r.start  = free_at[best];
        fin = {1'b0, free_at[best]} + dur;
        free_at[best] = (fin > TIME_MAX) ? TIME_MAX : fin[TB-1:0];
        return r;
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            assign_queue.push_back(schedule_job(i_job_duration));
            void'(job_queue.pop_front());
        end
        if (!i_valid || o_ready) begin
            if (src_gap > 0) begin
                src_gap <= src_gap - 1;
                i_valid <= 1'b0;
            end else if (job_queue.size() > 0) begin
                i_valid <= 1'b1;
                i_job_duration <= job_queue[0];
                src_gap <= gap_len();
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_assign exp_r;
        if (o_valid && i_ready) begin
            if (assign_queue.size() == 0) begin
                $error("result with no job pending: worker %0d start %0d",
                       o_worker_index, o_start_time);
                fail_count++;
            end else begin
                exp_r = assign_queue.pop_front();
                if (o_worker_index !== exp_r.worker) begin
                    $error("worker_index expected %0d actual %0d", exp_r.worker,
                           o_worker_index);
                    fail_count++;
                end
                if (o_start_time !== exp_r.start) begin
                    $error("start_time expected %0d actual %0d", exp_r.start,
                           o_start_time);
                    fail_count++;
                end
            end
        end
        if (hold_sink && hold_cnt < HOLD_LEN) begin
            hold_cnt <= hold_cnt + 1;
            i_ready <= 1'b0;
        end else if (sink_gap > 0) begin
            sink_gap <= sink_gap - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) sink_gap <= gap_len();
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || psel || !i_rst_n)
            idle_cycles <= 0;
        else if (job_queue.size() > 0 || assign_queue.size() > 0) begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    task automatic write_workers(input logic [efws_pkg::WC_BITS-1:0] val);
        @(posedge i_clk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= 2'(efws_pkg::REG_WORKER_COUNT * 4);
        pwdata <= 32'(val);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        workers_cfg = val;
        foreach (free_at[i]) free_at[i] = '0;
    endtask

    task automatic drain_all();
        while (job_queue.size() > 0 || assign_queue.size() > 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_dur();
        case ($urandom_range(0, 5))
            0: return 32'hFFFF_FFFF;
            1: return 32'd0;
            2: return $urandom_range(0, 15);
            default: return $urandom;
        endcase
    endfunction

    initial begin
        logic [efws_pkg::WC_BITS-1:0] settings [6];
        workers_cfg = efws_pkg::WC_RESET;
        foreach (free_at[i]) free_at[i] = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: one worker, extremes, zero duration
        job_queue.push_back(32'd0);
        job_queue.push_back(32'd5);
        job_queue.push_back(32'hFFFF_FFFF);
        job_queue.push_back(32'h0000_0001);
        job_queue.push_back(32'hAAAA_AAAA);
        job_queue.push_back(32'h5555_5555);
        drain_all();
        // back-to-back maximum durations on one worker
        write_workers(9'd1);
        repeat (8) job_queue.push_back(32'hFFFF_FFFF);
        drain_all();
        write_workers(9'd0);
        repeat (4) job_queue.push_back(32'd3);
        drain_all();
        write_workers(9'h1FF);
        repeat (6) job_queue.push_back(32'd0);
        drain_all();

        // long receiver hold while sender keeps offering
        write_workers(9'd4);
        hold_sink = 1'b1;
        repeat (20) job_queue.push_back(rand_dur());
        wait (hold_cnt == HOLD_LEN);
        hold_sink = 1'b0;
        drain_all();

        settings = '{9'd1, 9'd2, 9'd3, 9'd16, 9'd256, 9'd300};
        for (int p = 0; p < 6; p++) begin
            write_workers(settings[p]);
            repeat (150) job_queue.push_back(rand_dur());
            drain_all();
        end

        if (fail_count == 0) $display("No mismatches found");
        else $display("Mismatches found");
        $finish;
    end
endmodule
